/* rtl/assert_macros.svh */
// Assertion macros for the RTL files of the wavetable LFO.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/wtlfo_pkg.sv */
// Package for the wavetable LFO: sizes, reset values, function codes,
// register indexes and the digit-serial multiplier geometry. No dependencies.
package wtlfo_pkg;

   localparam int TABLE_LEN   = 512;
   localparam int INDEX_BITS  = $clog2(TABLE_LEN);
   localparam int FRAC_BITS   = 16;
   localparam int HEAD_BITS   = INDEX_BITS + FRAC_BITS;
   localparam int SAMPLE_BITS = 16;
   localparam int GAIN_BITS   = 18;
   localparam int OUT_BITS    = 18;
   localparam int INC_BITS    = 25;

   localparam logic [INC_BITS-1:0]  INC_RESET  = 25'd48696;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 18'd32768;

   // Stream payload widths (tdata padded to whole bytes)
   localparam int REQ_TDATA_BITS = 40;
   localparam int REQ_TUSER_BITS = 3;
   localparam int RSP_TDATA_BITS = 24;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = INC_BITS;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_INC = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN      = 1'd1;

   typedef enum logic [REQ_TUSER_BITS-1:0] {
      FUNC_TICK       = 3'd0,
      FUNC_WRITE      = 3'd1,
      FUNC_SET_PHASE  = 3'd2,
      FUNC_RESET_HEAD = 3'd3,
      FUNC_CLEAR_HEAD = 3'd4
   } func_type;

   // Digit-serial multiplier: signed A times B, B consumed 4 bits per cycle,
   // top digit of B taken as signed.
   localparam int MUL_A_BITS   = 18;
   localparam int MUL_B_BITS   = 20;
   localparam int DIGIT_BITS   = 4;
   localparam int MUL_DIGITS   = MUL_B_BITS / DIGIT_BITS;
   localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS);
   localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_BITS;
   localparam int MUL_PP_BITS  = MUL_A_BITS + DIGIT_BITS + 1;
   localparam int MUL_ACC_BITS = MUL_PP_BITS;

endpackage

/* rtl/wavetable_lfo_interpolating_top.sv */
// Wavetable LFO with linear interpolation, top level.
// Depends on wtlfo_pkg, wtlfo_dsmul and assert_macros.svh.
//
// Usage:
//   req_* carries requests: req_tuser holds the function (tick, table write,
//   set phase, reset head to phase, clear head), req_tdata the table address,
//   table sample and phase offset. Only a tick gives a result on rsp_*.
//   csr_* writes phase_increment (index 0) or gain (index 1); csr_ready is
//   always high. Write registers only while no tick is in flight.
//   Non-tick requests complete in ST_IDLE and leave req_tready high. A tick
//   reads two table entries from a single-port 512x16 memory, then runs two
//   products through one shared 4-bit-digit serial multiplier; req_tready
//   returns in the same cycle as the result enters the output register. The
//   multiplier passes set the tick rate.
//   The output register holds one result; while rsp_tready stays low the
//   block still takes requests, but a following tick waits at its last step
//   until the held result is taken.
//   Reset (synchronous, active high) clears the head and phase offset and
//   restores the register defaults; table contents are not cleared and must
//   be written before they are read.
`include "assert_macros.svh"

module wavetable_lfo_interpolating_top
   import wtlfo_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [REQ_TDATA_BITS-1:0]    req_tdata,  // table_addr, table_data, phase_samples
   input  logic [REQ_TUSER_BITS-1:0]    req_tuser,  // func
   // result channel
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]    rsp_tdata,  // sample_out
   // register writes
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_data
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_RD1   = 8'b0000_0010,
      ST_RD2   = 8'b0000_0100,
      ST_MUL1  = 8'b0000_1000,
      ST_WAIT1 = 8'b0001_0000,
      ST_MUL2  = 8'b0010_0000,
      ST_WAIT2 = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [INC_BITS-1:0]          inc_ff;
   logic [GAIN_BITS-1:0]         gain_ff;
   logic [HEAD_BITS-1:0]         head_ff, head_in;
   logic [INDEX_BITS-1:0]        offset_ff, offset_in;

   logic [SAMPLE_BITS-1:0]       wave_mem [TABLE_LEN];
   logic [SAMPLE_BITS-1:0]       rd_data_ff;
   logic [SAMPLE_BITS-1:0]       s1_ff;
   logic [SAMPLE_BITS-1:0]       v15_ff, v15_in;
   logic [OUT_BITS-1:0]          res_ff, res_in;
   logic                         rsp_valid_ff;
   logic [OUT_BITS-1:0]          rsp_data_ff;

   logic                         req_accept;
   func_type                     req_func;
   logic [INDEX_BITS-1:0]        req_addr;
   logic [SAMPLE_BITS-1:0]       req_sample;
   logic [INDEX_BITS-1:0]        req_phase;
   logic                         mem_we;
   logic [INDEX_BITS-1:0]        rd_addr;
   logic [INDEX_BITS-1:0]        head_idx;
   logic                         out_free;

   logic                         mul_start;
   logic                         mul_done;
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic        [MUL_B_BITS-1:0] mul_b;
   logic signed [MUL_P_BITS-1:0] mul_p;
   logic signed [SAMPLE_BITS:0]  diff;
   logic signed [33:0]           v_sum;
   logic signed [34:0]           r_sum;
   logic signed [19:0]           r_val;

   // field unpacking
   assign req_func   = func_type'(req_tuser);
   assign req_addr   = req_tdata[8:0];
   assign req_sample = req_tdata[24:9];
   assign req_phase  = req_tdata[33:25];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign head_idx   = head_ff[HEAD_BITS-1:FRAC_BITS];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff  <= INC_RESET;
         gain_ff <= GAIN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PHASE_INC: inc_ff  <= csr_data;
            CSR_GAIN:      gain_ff <= csr_data[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // table memory, one port: write on table requests, read during a tick
   assign rd_addr = (state_ff == ST_RD2) ? head_idx + 1'b1 : head_idx;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         wave_mem[req_addr] <= req_sample;
      end
      rd_data_ff <= wave_mem[rd_addr];
   end

   // multiplier operands: slope times fraction, then sample times gain
   assign diff      = $signed({1'b0, rd_data_ff}) - $signed({1'b0, s1_ff})
                    + $signed({rd_data_ff[SAMPLE_BITS-1], {SAMPLE_BITS{1'b0}}})
                    - $signed({s1_ff[SAMPLE_BITS-1], {SAMPLE_BITS{1'b0}}});
   assign mul_start = (state_ff == ST_MUL1) || (state_ff == ST_MUL2);
   assign mul_a     = (state_ff == ST_MUL1)
                    ? $signed({diff[SAMPLE_BITS], diff})
                    : $signed({{(MUL_A_BITS-SAMPLE_BITS){v15_ff[SAMPLE_BITS-1]}}, v15_ff});
   assign mul_b     = (state_ff == ST_MUL1)
                    ? {{(MUL_B_BITS-FRAC_BITS){1'b0}}, head_ff[FRAC_BITS-1:0]}
                    : {{(MUL_B_BITS-GAIN_BITS){gain_ff[GAIN_BITS-1]}}, gain_ff};

   wtlfo_dsmul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // s1 * 2^16 + slope * frac, rounded to Q.15
   assign v_sum = $signed({{2{s1_ff[SAMPLE_BITS-1]}}, s1_ff, {FRAC_BITS{1'b0}}})
                + mul_p[33:0] + 34'sd32768;
   assign v15_in = v_sum[31:16];

   // times gain, rounded to Q2.15 and saturated
   assign r_sum = mul_p[34:0] + 35'sd16384;
   assign r_val = r_sum[34:15];

   always_comb begin
      if (!r_val[19] && (r_val[18:17] != 2'b00)) begin
         res_in = {1'b0, {(OUT_BITS-1){1'b1}}};
      end else if (r_val[19] && (r_val[18:17] != 2'b11)) begin
         res_in = {1'b1, {(OUT_BITS-1){1'b0}}};
      end else begin
         res_in = r_val[OUT_BITS-1:0];
      end
   end

   // control
   always_comb begin
      state_in  = state_ff;
      head_in   = head_ff;
      offset_in = offset_ff;
      mem_we    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_TICK: begin
                     head_in  = head_ff + inc_ff;
                     state_in = ST_RD1;
                  end
                  FUNC_WRITE: begin
                     mem_we = 1'b1;
                  end
                  FUNC_SET_PHASE: begin
                     // head moves by the change of the offset, wrapping
                     head_in   = {head_idx + req_phase - offset_ff,
                                  head_ff[FRAC_BITS-1:0]};
                     offset_in = req_phase;
                  end
                  FUNC_RESET_HEAD: begin
                     head_in = {offset_ff, {FRAC_BITS{1'b0}}};
                  end
                  FUNC_CLEAR_HEAD: begin
                     head_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD1:   state_in = ST_RD2;
         ST_RD2:   state_in = ST_MUL1;
         ST_MUL1:  state_in = ST_WAIT1;
         ST_WAIT1: begin
            if (mul_done) begin
               state_in = ST_MUL2;
            end
         end
         ST_MUL2:  state_in = ST_WAIT2;
         ST_WAIT2: begin
            if (mul_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         offset_ff <= offset_in;
         if ((state_ff == ST_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_RD2) begin
         s1_ff <= rd_data_ff;
      end
      if ((state_ff == ST_WAIT1) && mul_done) begin
         v15_ff <= v15_in;
      end
      if ((state_ff == ST_WAIT2) && mul_done) begin
         res_ff <= res_in;
      end
      if ((state_ff == ST_OUT) && out_free) begin
         rsp_data_ff <= res_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS-OUT_BITS){1'b0}}, rsp_data_ff};

   // checks
   `ASSERT_SAME(a_mul_done_in_wait, clock, reset, mul_done,
      (state_ff == ST_WAIT1) || (state_ff == ST_WAIT2),
      "multiplier finished outside a wait state")
   `ASSERT_NEXT(a_tick_starts_read, clock, reset,
      req_accept && (req_func == FUNC_TICK), state_ff == ST_RD1,
      "accepted tick did not start the table read")
   `ASSERT_NEXT(a_out_loads, clock, reset, (state_ff == ST_OUT) && out_free,
      rsp_valid_ff && (state_ff == ST_IDLE),
      "finished tick was not moved to the output register")

endmodule

/* rtl/wtlfo_dsmul.sv */
// Digit-serial signed multiplier, one 4-bit digit of the multiplier per cycle.
// Depends on wtlfo_pkg.
module wtlfo_dsmul
   import wtlfo_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic signed [MUL_A_BITS-1:0] mcand,
   input  logic        [MUL_B_BITS-1:0] mplier,
   output logic                         done,
   output logic signed [MUL_P_BITS-1:0] product
);

   logic signed [MUL_A_BITS-1:0]   a_ff;
   logic        [MUL_B_BITS-1:0]   b_ff;
   logic signed [MUL_ACC_BITS-1:0] hi_ff;
   logic        [MUL_B_BITS-1:0]   lo_ff;
   logic        [MUL_CNT_BITS-1:0] cnt_ff;
   logic                           busy_ff;
   logic                           done_ff;

   logic signed [DIGIT_BITS:0]     digit;
   logic signed [MUL_PP_BITS-1:0]  pp;
   logic signed [MUL_ACC_BITS-1:0] sum;
   logic                           last_digit;

   assign last_digit = (cnt_ff == MUL_CNT_BITS'(MUL_DIGITS - 1));

   always_comb begin
      // low digits are unsigned, the top one carries the sign
      digit = last_digit ? $signed({b_ff[DIGIT_BITS-1], b_ff[DIGIT_BITS-1:0]})
                         : $signed({1'b0, b_ff[DIGIT_BITS-1:0]});
      pp    = $signed({{(MUL_PP_BITS-MUL_A_BITS){a_ff[MUL_A_BITS-1]}}, a_ff})
            * $signed({{(MUL_PP_BITS-DIGIT_BITS-1){digit[DIGIT_BITS]}}, digit});
      sum   = hi_ff + pp;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff  <= cnt_ff + 1'b1;
         busy_ff <= !last_digit;
         done_ff <= last_digit;
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff  <= mcand;
         b_ff  <= mplier;
         hi_ff <= '0;
         lo_ff <= '0;
      end else if (busy_ff) begin
         b_ff  <= b_ff >> DIGIT_BITS;
         hi_ff <= sum >>> DIGIT_BITS;
         lo_ff <= {sum[DIGIT_BITS-1:0], lo_ff[MUL_B_BITS-1:DIGIT_BITS]};
      end
   end

   assign done    = done_ff;
   assign product = $signed({hi_ff[MUL_A_BITS-1:0], lo_ff});

endmodule
